>>> src/wmm_pkg.sv
// ----------------------------------------------------------------------------
// wmm_pkg
// Shared field widths and command codes for the Winograd matrix multiplier.
// ----------------------------------------------------------------------------
package wmm_pkg;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 3;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int DIM_W  = 4;

    localparam logic [CMD_W-1:0] CMD_WR_A    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_B    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

endpackage

>>> src/wmm_if.sv
// ----------------------------------------------------------------------------
// wmm_if
// Valid/ready channels: command items in, product items out.
// ----------------------------------------------------------------------------
interface wmm_in_if;
    import wmm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, cmd, row, col, value, input ready);
    modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

interface wmm_out_if;
    import wmm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [PROD_W-1:0] product;
    logic                     last;

    modport source (output valid, out_row, out_col, product, last, input ready);
    modport sink   (input valid, out_row, out_col, product, last, output ready);
endinterface

>>> src/wmm_ram.sv
// ----------------------------------------------------------------------------
// wmm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module wmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr0,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata0,
    output logic [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

>>> src/winograd_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// winograd_matrix_multiply_top
// Square signed matrix product by Winograd's pairwise scheme, one shared
// multiplier under a sequencer.
//
// Input channel i_in carries items: write A element, write B element, or
// compute. A write produces nothing. A compute item keeps i_in.ready low
// until its last result has been loaded into the output register. It emits
// n*n items on o_out in row-major order, last set on the final one. n comes
// from the dim register (i_cfg_we/i_cfg_wdata), clamped to 1..MAX_DIM. It is
// to be written only while the block is idle; the block does not enforce it.
// Every multiply step runs through address, RAM read, multiply and accumulate
// with the single multiplier. A compute item runs a factor pass (row factors,
// then column factors) and then a product pass, which an output stall can
// hold.
// The output register holds one item; a stalled receiver holds the
// sequencer in its emit state without losing anything.
// Reset (synchronous, active low) returns the sequencer to idle, drops the
// output valid and sets dim to 8. Matrix contents are undefined until written.
// ----------------------------------------------------------------------------
module winograd_matrix_multiply_top #(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    wmm_in_if.sink                     i_in,
    wmm_out_if.source                  o_out,
    input  logic                       i_cfg_we,
    input  logic [wmm_pkg::DIM_W-1:0]  i_cfg_wdata
);
    import wmm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int NW    = $clog2(MAX_DIM + 1);
    localparam int KW    = $clog2(MAX_DIM / 2 + 2);

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_CHK, S_RD, S_MUL, S_ACC, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        M_ROW, M_COL, M_PROD
    } t_mode;

    t_state            r_state;
    t_mode             r_mode;
    logic [DIM_W-1:0]  r_dim;
    logic [NW-1:0]     r_n;
    logic [IW-1:0]     r_i;
    logic [IW-1:0]     r_j;
    logic [KW-1:0]     r_k;
    logic [PROD_W-1:0] r_acc;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_row_fac [MAX_DIM];
    logic [PROD_W-1:0] r_col_fac [MAX_DIM];
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_row;
    logic [IDX_W-1:0]  r_out_col;
    logic [PROD_W-1:0] r_out_prod;
    logic              r_out_last;

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    function automatic logic [PROD_W-1:0] f_sext(input logic [ELEM_BITS-1:0] e);
        return PROD_W'(signed'(e));
    endfunction

    // ---- load path ----
    logic w_in_acc, w_idx_ok, w_we_a, w_we_b;
    logic [AW-1:0]        w_waddr;
    logic [ELEM_BITS-1:0] w_wdata;

    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_idx_ok = (int'(i_in.row) < MAX_DIM) && (int'(i_in.col) < MAX_DIM);
    assign w_we_a   = w_in_acc && w_idx_ok && (i_in.cmd == CMD_WR_A);
    assign w_we_b   = w_in_acc && w_idx_ok && (i_in.cmd == CMD_WR_B);
    assign w_waddr  = f_addr(IW'(i_in.row), IW'(i_in.col));
    // value is taken zero-extended, then sign-extended from ELEM_BITS-1 on read
    assign w_wdata  = ELEM_BITS'($unsigned(i_in.value));

    // ---- step control ----
    logic [NW-1:0] w_half;
    logic [IW-1:0] w_nm1;
    logic          w_odd_step, w_step_go, w_last_i, w_last_j, w_slot_free;
    logic [IW-1:0] w_k2, w_k2p1;
    logic [NW-1:0] w_n_clamp;

    assign w_half      = r_n >> 1;
    assign w_nm1       = IW'(r_n - 1'b1);
    assign w_odd_step  = (r_mode == M_PROD) && r_n[0] && (NW'(r_k) == w_half);
    assign w_step_go   = (NW'(r_k) < w_half) || w_odd_step;
    assign w_last_i    = (r_i == w_nm1);
    assign w_last_j    = (r_j == w_nm1);
    assign w_k2        = IW'({r_k, 1'b0});
    assign w_k2p1      = IW'({r_k, 1'b1});
    assign w_slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        if (r_dim == '0) begin
            w_n_clamp = NW'(1);
        end else if (int'(r_dim) > MAX_DIM) begin
            w_n_clamp = NW'(MAX_DIM);
        end else begin
            w_n_clamp = NW'(r_dim);
        end
    end

    // ---- matrix RAMs ----
    logic [AW-1:0]        w_ra0, w_ra1, w_rb0, w_rb1;
    logic [ELEM_BITS-1:0] w_qa0, w_qa1, w_qb0, w_qb1;

    // odd step reads A[i][n-1] and B[n-1][j]
    assign w_ra0 = f_addr(r_i, w_odd_step ? w_nm1 : w_k2);
    assign w_ra1 = f_addr(r_i, w_odd_step ? w_nm1 : w_k2p1);
    assign w_rb0 = f_addr(w_odd_step ? w_nm1 : w_k2, r_j);
    assign w_rb1 = f_addr(w_odd_step ? w_nm1 : w_k2p1, r_j);

    wmm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH), .AW(AW)) u_ram_a (
        .i_clk    (i_clk),
        .i_we     (w_we_a),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr0 (w_ra0),
        .i_raddr1 (w_ra1),
        .o_rdata0 (w_qa0),
        .o_rdata1 (w_qa1)
    );

    wmm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH), .AW(AW)) u_ram_b (
        .i_clk    (i_clk),
        .i_we     (w_we_b),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr0 (w_rb0),
        .i_raddr1 (w_rb1),
        .o_rdata0 (w_qb0),
        .o_rdata1 (w_qb1)
    );

    // ---- shared multiplier operands ----
    logic [PROD_W-1:0] w_ea0, w_ea1, w_eb0, w_eb1, w_x, w_y;

    assign w_ea0 = f_sext(w_qa0);
    assign w_ea1 = f_sext(w_qa1);
    assign w_eb0 = f_sext(w_qb0);
    assign w_eb1 = f_sext(w_qb1);

    always_comb begin
        case (r_mode)
            M_ROW: begin
                w_x = w_ea0;
                w_y = w_ea1;
            end
            M_COL: begin
                w_x = w_eb0;
                w_y = w_eb1;
            end
            M_PROD: begin
                if (w_odd_step) begin
                    w_x = w_ea0;
                    w_y = w_eb0;
                end else begin
                    w_x = w_ea0 + w_eb1;
                    w_y = w_ea1 + w_eb0;
                end
            end
            default: begin
                w_x = '0;
                w_y = '0;
            end
        endcase
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_ROW;
            r_out_valid <= 1'b0;
            r_dim       <= DIM_RESET;
        end else begin
            if (i_cfg_we) begin
                r_dim <= i_cfg_wdata;
            end
            if (r_state == S_EMIT && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_in.cmd == CMD_COMPUTE) begin
                        r_n     <= w_n_clamp;
                        r_mode  <= M_ROW;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_state <= S_CHK;
                    end
                end
                S_INIT: begin
                    r_acc   <= PROD_W'(0) - r_row_fac[r_i] - r_col_fac[r_j];
                    r_k     <= '0;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_step_go) begin
                        r_state <= S_RD;
                    end else begin
                        case (r_mode)
                            M_ROW: begin
                                r_row_fac[r_i] <= r_acc;
                                r_acc <= '0;
                                r_k   <= '0;
                                if (w_last_i) begin
                                    r_mode <= M_COL;
                                    r_j    <= '0;
                                end else begin
                                    r_i <= r_i + 1'b1;
                                end
                            end
                            M_COL: begin
                                r_col_fac[r_j] <= r_acc;
                                r_acc <= '0;
                                r_k   <= '0;
                                if (w_last_j) begin
                                    r_mode  <= M_PROD;
                                    r_i     <= '0;
                                    r_j     <= '0;
                                    r_state <= S_INIT;
                                end else begin
                                    r_j <= r_j + 1'b1;
                                end
                            end
                            default: begin
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= w_x * w_y;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= r_acc + r_prod;
                    r_k     <= r_k + 1'b1;
                    r_state <= S_CHK;
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_row   <= IDX_W'(r_i);
                        r_out_col   <= IDX_W'(r_j);
                        r_out_prod  <= r_acc;
                        r_out_last  <= w_last_i && w_last_j;
                        if (w_last_j) begin
                            r_j <= '0;
                            if (w_last_i) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_INIT;
                            end
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_INIT;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.out_row = r_out_row;
    assign o_out.out_col = r_out_col;
    assign o_out.product = r_out_prod;
    assign o_out.last    = r_out_last;

    // ---- assertions ----
    a_mul_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |-> $past(r_state) == S_RD)
        else $error("multiply without a preceding RAM read cycle");

    a_k_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> NW'(r_k) <= w_half + 1'b1)
        else $error("pair counter ran past the last pair");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && w_slot_free |=> r_out_valid)
        else $error("emit state did not load the output register");

    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_row == r_out_col)
        else $error("last flag on a non-final element");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && !w_slot_free |=> r_state == S_EMIT)
        else $error("sequencer advanced while the output was stalled");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the Winograd matrix multiplier. A short table of directed items
// runs first, then random load/compute sequences across several sizes,
// including out-of-range settings. Every product item is compared field by
// field against the table's typed product or an in-bench predictor of the
// pairwise scheme. Both channels idle and stall at random, but for one steady phase.
// ----------------------------------------------------------------------------
module tb_top;
    import wmm_pkg::*;

    localparam int MAX_DIM   = 8;
    localparam int LIMIT     = 400000;
    localparam int MAX_NOTES = 100;

    localparam logic [CMD_W-1:0] CMD_UNDEF = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]         r;
        logic [IDX_W-1:0]         c;
        logic signed [PROD_W-1:0] p;
        logic                     last;
    } t_prod;

    typedef struct packed {
        logic                    is_cfg;
        logic [CMD_W-1:0]        cmd;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    typed;
        logic [PROD_W-1:0]       exp_p;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [DIM_W-1:0]   i_cfg_wdata;

    wmm_in_if  in_if ();
    wmm_out_if out_if ();

    winograd_matrix_multiply_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_prod            expected_products[$];
    bit [31:0]        shadow_a [MAX_DIM*MAX_DIM];
    bit [31:0]        shadow_b [MAX_DIM*MAX_DIM];
    bit               a_loaded [MAX_DIM*MAX_DIM];
    bit               b_loaded [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0] shadow_dim;
    int               errors = 0;
    int               cycles = 0;
    bit               steady;
    t_dir_row         dir_rows [0:20];

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_NOTES)
            $display("mismatch @%0d: %s", cycles, msg);
    endtask

    function automatic int eff_dim(input logic [DIM_W-1:0] d);
        int n;
        n = int'(d);
        if (n < 1) n = 1;
        if (n > MAX_DIM) n = MAX_DIM;
        return n;
    endfunction

    // row factors, column factors, then paired sums, all mod 2^32
    task automatic predict_products();
        int        n;
        int        half;
        bit [31:0] rf [MAX_DIM];
        bit [31:0] cf [MAX_DIM];
        bit [31:0] acc;
        t_prod     e;
        n    = eff_dim(shadow_dim);
        half = n / 2;
        for (int i = 0; i < n; i++) begin
            rf[i] = 0;
            cf[i] = 0;
            for (int k = 0; k < half; k++) begin
                rf[i] += shadow_a[i*MAX_DIM + 2*k] * shadow_a[i*MAX_DIM + 2*k + 1];
                cf[i] += shadow_b[2*k*MAX_DIM + i] * shadow_b[(2*k + 1)*MAX_DIM + i];
            end
        end
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = 32'd0 - rf[i] - cf[j];
                for (int k = 0; k < half; k++)
                    acc += (shadow_a[i*MAX_DIM + 2*k] + shadow_b[(2*k + 1)*MAX_DIM + j])
                         * (shadow_a[i*MAX_DIM + 2*k + 1] + shadow_b[2*k*MAX_DIM + j]);
                if (n % 2)
                    acc += shadow_a[i*MAX_DIM + n - 1] * shadow_b[(n - 1)*MAX_DIM + j];
                e.r    = 3'(i);
                e.c    = 3'(j);
                e.p    = acc;
                e.last = (i == n - 1) && (j == n - 1);
                expected_products.push_back(e);
            end
        end
    endtask

    task automatic track_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col, input logic signed [VAL_W-1:0] v);
        int idx;
        idx = int'(row) * MAX_DIM + int'(col);
        case (cmd)
            CMD_WR_A: begin
                shadow_a[idx] = {{(32-VAL_W){v[VAL_W-1]}}, v};
                a_loaded[idx] = 1'b1;
            end
            CMD_WR_B: begin
                shadow_b[idx] = {{(32-VAL_W){v[VAL_W-1]}}, v};
                b_loaded[idx] = 1'b1;
            end
            CMD_COMPUTE: predict_products();
            default: ;
        endcase
    endtask

    // valid stays high from one item to the next unless the sender idles
    task automatic drive_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col, input logic signed [VAL_W-1:0] v);
        while (!steady && $urandom_range(99) < 36) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.cmd   <= cmd;
        in_if.row   <= row;
        in_if.col   <= col;
        in_if.value <= v;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                        input logic [IDX_W-1:0] col, input logic signed [VAL_W-1:0] v);
        drive_item(cmd, row, col, v);
        track_item(cmd, row, col, v);
    endtask

    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (expected_products.size() != 0) @(posedge i_clk);
    endtask

    // idle block only: drain, let a pending load retire, then write
    task automatic write_dim(input logic [DIM_W-1:0] d);
        wait_drain();
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_dim   = d;
    endtask

    function automatic logic signed [VAL_W-1:0] rand_value();
        logic signed [VAL_W-1:0] corner [4];
        corner = '{-16'sd32768, 16'sd32767, -16'sd1, 16'sd0};
        if ($urandom_range(3) == 0)
            return corner[$urandom_range(3)];
        return VAL_W'($urandom);
    endfunction

    function automatic logic [IDX_W-1:0] rand_index(input int n);
        if ($urandom_range(4) == 0)
            return IDX_W'($urandom_range(MAX_DIM - 1));
        return IDX_W'($urandom_range(n - 1));
    endfunction

    task automatic random_load(input int n);
        logic [CMD_W-1:0] cmd;
        cmd = $urandom_range(1) ? CMD_WR_A : CMD_WR_B;
        if ($urandom_range(7) == 0)
            cmd = CMD_UNDEF;
        send(cmd, rand_index(n), rand_index(n), rand_value());
    endtask

    // never compute over an element that was never loaded
    task automatic fill_missing(input int n);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                if (!a_loaded[i*MAX_DIM + j])
                    send(CMD_WR_A, 3'(i), 3'(j), rand_value());
                if (!b_loaded[i*MAX_DIM + j])
                    send(CMD_WR_B, 3'(i), 3'(j), rand_value());
            end
    endtask

    task automatic random_compute();
        send(CMD_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
    endtask

    function automatic t_dir_row cfg_row(input logic [DIM_W-1:0] d);
        return '{1'b1, CMD_UNDEF, 3'd0, 3'd0, VAL_W'(d), 1'b0, 32'd0};
    endfunction

    function automatic t_dir_row item_row(input logic [CMD_W-1:0] cmd,
                                          input logic [IDX_W-1:0] row,
                                          input logic [IDX_W-1:0] col,
                                          input logic signed [VAL_W-1:0] v);
        return '{1'b0, cmd, row, col, v, 1'b0, 32'd0};
    endfunction

    // single-element compute with its product written in
    function automatic t_dir_row typed_row(input logic [PROD_W-1:0] p);
        return '{1'b0, CMD_COMPUTE, 3'd0, 3'd0, 16'sd0, 1'b1, p};
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_products.size() == 0) begin
                    report_mismatch($sformatf("unexpected product (%0d,%0d) %0d",
                        out_if.out_row, out_if.out_col, out_if.product));
                end else begin
                    t_prod want;
                    want = expected_products.pop_front();
                    if (out_if.out_row !== want.r)
                        report_mismatch($sformatf("out_row %0d, want %0d",
                            out_if.out_row, want.r));
                    if (out_if.out_col !== want.c)
                        report_mismatch($sformatf("out_col %0d, want %0d",
                            out_if.out_col, want.c));
                    if (out_if.product !== want.p)
                        report_mismatch($sformatf("product (%0d,%0d) %0d, want %0d",
                            want.r, want.c, out_if.product, want.p));
                    if (out_if.last !== want.last)
                        report_mismatch($sformatf("last (%0d,%0d) %0b, want %0b",
                            want.r, want.c, out_if.last, want.last));
                end
            end
            out_if.ready <= steady || ($urandom_range(99) >= 36);
        end
    end

    initial begin
        int dims [9];
        int n;
        dims = '{3, 5, 2, 7, 1, 8, 6, 15, 0};

        steady       = 1'b0;
        shadow_dim   = DIM_RESET;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        in_if.valid <= 1'b0;
        in_if.cmd   <= CMD_WR_A;
        in_if.row   <= '0;
        in_if.col   <= '0;
        in_if.value <= '0;

        dir_rows = '{
            cfg_row(4'd1),
            item_row(CMD_WR_A, 3'd0, 3'd0, -16'sd32768),
            item_row(CMD_WR_B, 3'd0, 3'd0, -16'sd32768),
            typed_row(32'h4000_0000),
            item_row(CMD_UNDEF, 3'd7, 3'd7, -16'sd1),     // undefined command
            item_row(CMD_WR_A, 3'd0, 3'd0, 16'sd32767),
            typed_row(32'hC000_8000),
            cfg_row(4'd0),                                // size zero acts as one
            typed_row(32'hC000_8000),
            cfg_row(4'd2),
            item_row(CMD_WR_A, 3'd0, 3'd1, 16'sd32767),
            item_row(CMD_WR_A, 3'd1, 3'd0, -16'sd32768),
            item_row(CMD_WR_A, 3'd1, 3'd1, 16'sd0),
            item_row(CMD_WR_B, 3'd0, 3'd1, -16'sd1),
            item_row(CMD_WR_B, 3'd1, 3'd0, 16'sd32767),
            item_row(CMD_WR_B, 3'd1, 3'd1, -16'sd32768),
            item_row(CMD_WR_A, 3'd7, 3'd7, 16'sd12345),   // outside size, still stored
            item_row(CMD_WR_B, 3'd7, 3'd7, -16'sd2),
            item_row(CMD_COMPUTE, 3'd7, 3'd7, -16'sd1),
            item_row(CMD_WR_A, 3'd0, 3'd0, -16'sd32768),
            item_row(CMD_COMPUTE, 3'd0, 3'd0, 16'sd0)
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                write_dim(dir_rows[r].value[DIM_W-1:0]);
            end else begin
                drive_item(dir_rows[r].cmd, dir_rows[r].row, dir_rows[r].col,
                           dir_rows[r].value);
                if (dir_rows[r].typed)
                    expected_products.push_back('{3'd0, 3'd0, dir_rows[r].exp_p, 1'b1});
                else
                    track_item(dir_rows[r].cmd, dir_rows[r].row, dir_rows[r].col,
                               dir_rows[r].value);
            end
        end

        foreach (dims[ph]) begin
            write_dim(DIM_W'(dims[ph]));
            n = eff_dim(shadow_dim);
            steady = (ph == 5);
            repeat ($urandom_range(2, 8)) random_load(n);
            fill_missing(n);
            random_compute();
            if (ph == 3)
                wait_drain();
            repeat ($urandom_range(1, 4)) random_load(n);
            fill_missing(n);
            random_compute();
        end
        steady = 1'b0;

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
src/wmm_pkg.sv
src/wmm_if.sv
src/wmm_ram.sv
src/winograd_matrix_multiply_top.sv
bench/tb_top.sv
